// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/txrcp_pkg.sv =====
`default_nettype none

package txrcp_pkg;

    localparam int RING_DEPTH  = 256;
    localparam int CHUNK_BYTES = 63;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int RUN_W  = $clog2(CHUNK_BYTES + 1);
    localparam int CALC_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REFUSE = 2'd1;
    localparam logic [1:0] KIND_CHUNK  = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_DONE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_PUMP_START,
        ST_PUMP_READ,
        ST_PUMP_LOAD
    } state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(RING_DEPTH - 1))
            return '0;
        else
            return i + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tx_frame_ring_chunk_pump_top.sv =====
// order: an admission result is registered in ST_ADMIT after its transaction; the first
// chunk byte passes ST_PUMP_START, ST_PUMP_READ and ST_PUMP_LOAD, each later byte again
// ST_PUMP_READ and ST_PUMP_LOAD; a frame byte is taken in ST_IDLE and also passes ST_ADMIT
// when it opens a frame; no new input is taken while the pump runs; the pace is set by the
// registered read of the ring memory and one output register; a stalled receiver holds ST_ADMIT and ST_PUMP_LOAD
// reset: pointers and flags clear at once; the output payload and ring memory are not cleared
`default_nettype none

module tx_frame_ring_chunk_pump_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_of_frame,
    input  wire logic       last_of_frame,
    input  wire logic [7:0] frame_length,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic            last_of_chunk
);

    localparam int IDX_W  = txrcp_pkg::IDX_W;
    localparam int RUN_W  = txrcp_pkg::RUN_W;
    localparam int CALC_W = txrcp_pkg::CALC_W;

    logic [7:0] ring_mem [txrcp_pkg::RING_DEPTH];

    txrcp_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              in_flight_reg, in_flight_next;
    logic              discard_reg, discard_next;
    logic [7:0]        left_reg, left_next;
    logic              pump_req_reg, pump_req_next;
    logic [1:0]        admit_kind_reg, admit_kind_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              last_rd_reg, last_rd_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    logic              mem_we;
    logic              mem_re;
    logic [7:0]        rdata_reg;

    logic              out_free;
    logic [CALC_W-1:0] head_ext, tail_ext, depth_ext, len_ext;
    logic [CALC_W-1:0] used, to_end, free_slots, run_calc;

    assign in_ready      = (state_reg == txrcp_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_byte      = byte_reg;
    assign last_of_chunk = last_reg;
    assign out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        head_ext  = CALC_W'(head_reg);
        tail_ext  = CALC_W'(tail_reg);
        depth_ext = CALC_W'(txrcp_pkg::RING_DEPTH);
        len_ext   = CALC_W'(frame_length);
        if (head_reg >= tail_reg)
            used = head_ext - tail_ext;
        else
            used = head_ext + depth_ext - tail_ext;
        if (tail_reg > head_reg)
            free_slots = tail_ext - head_ext - 1'b1;
        else
            free_slots = tail_ext + depth_ext - head_ext - 1'b1;
        to_end   = depth_ext - tail_ext;
        run_calc = (to_end < used) ? to_end : used;
        if (run_calc > CALC_W'(txrcp_pkg::CHUNK_BYTES))
            run_calc = CALC_W'(txrcp_pkg::CHUNK_BYTES);
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        in_flight_next  = in_flight_reg;
        discard_next    = discard_reg;
        left_next       = left_reg;
        pump_req_next   = pump_req_reg;
        admit_kind_next = admit_kind_reg;
        run_next        = run_reg;
        last_rd_next    = last_rd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        unique case (state_reg)
            txrcp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == txrcp_pkg::CMD_DONE)
                    begin
                        in_flight_next = 1'b0;
                        state_next     = txrcp_pkg::ST_PUMP_START;
                    end
                    else
                    begin
                        pump_req_next = 1'b0;
                        if (first_of_frame)
                        begin
                            if (len_ext >= depth_ext || len_ext > free_slots)
                            begin
                                discard_next    = 1'b1;
                                left_next       = '0;
                                admit_kind_next = txrcp_pkg::KIND_REFUSE;
                            end
                            else
                            begin
                                discard_next    = 1'b0;
                                left_next       = frame_length;
                                admit_kind_next = txrcp_pkg::KIND_ACCEPT;
                            end
                        end
                        if (!discard_next && left_next != '0)
                        begin
                            mem_we    = 1'b1;
                            head_next = txrcp_pkg::idx_inc(head_reg);
                            left_next = left_next - 1'b1;
                        end
                        if (last_of_frame)
                        begin
                            left_next = '0;
                            if (discard_next)
                                discard_next = 1'b0;
                            else
                                pump_req_next = 1'b1;
                        end
                        if (first_of_frame)
                            state_next = txrcp_pkg::ST_ADMIT;
                        else if (pump_req_next)
                            state_next = txrcp_pkg::ST_PUMP_START;
                    end
                end
            end
            txrcp_pkg::ST_ADMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = admit_kind_reg;
                    byte_next      = '0;
                    last_next      = 1'b0;
                    state_next     = pump_req_reg ? txrcp_pkg::ST_PUMP_START
                                                  : txrcp_pkg::ST_IDLE;
                end
            end
            txrcp_pkg::ST_PUMP_START:
            begin
                if (in_flight_reg || tail_reg == head_reg)
                    state_next = txrcp_pkg::ST_IDLE;
                else
                begin
                    run_next       = RUN_W'(run_calc);
                    in_flight_next = 1'b1;
                    state_next     = txrcp_pkg::ST_PUMP_READ;
                end
            end
            txrcp_pkg::ST_PUMP_READ:
            begin
                mem_re       = 1'b1;
                tail_next    = txrcp_pkg::idx_inc(tail_reg);
                run_next     = run_reg - 1'b1;
                last_rd_next = (run_reg == RUN_W'(1));
                state_next   = txrcp_pkg::ST_PUMP_LOAD;
            end
            txrcp_pkg::ST_PUMP_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = txrcp_pkg::KIND_CHUNK;
                    byte_next      = rdata_reg;
                    last_next      = last_rd_reg;
                    state_next     = last_rd_reg ? txrcp_pkg::ST_IDLE
                                                 : txrcp_pkg::ST_PUMP_READ;
                end
            end
            default:
            begin
                state_next = txrcp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= txrcp_pkg::ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            in_flight_reg  <= 1'b0;
            discard_reg    <= 1'b0;
            left_reg       <= '0;
            pump_req_reg   <= 1'b0;
            run_reg        <= '0;
            last_rd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            in_flight_reg  <= in_flight_next;
            discard_reg    <= discard_next;
            left_reg       <= left_next;
            pump_req_reg   <= pump_req_next;
            run_reg        <= run_next;
            last_rd_reg    <= last_rd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        admit_kind_reg <= admit_kind_next;
        kind_reg       <= kind_next;
        byte_reg       <= byte_next;
        last_reg       <= last_next;
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[head_reg] <= data_byte;
        if (mem_re)
            rdata_reg <= ring_mem[tail_reg];
    end

endmodule

`default_nettype wire

// ===== hdl/txrcp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module txrcp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       command,
    input wire logic       first_of_frame,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_chunk
);

    // stalled result transaction holds its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(out_byte) && $stable(last_of_chunk))

    `ASSERT_NEVER(a_kind_code, clk, rst_n, out_valid && kind == 2'd3)

    // admission results carry no byte and no chunk mark
    `ASSERT_IMPLY(a_admit_clean, clk, rst_n, out_valid && kind != txrcp_pkg::KIND_CHUNK, out_byte == 8'd0 && !last_of_chunk)

    // a frame start always produces an admission result, so input stalls next cycle
    `ASSERT_NEXT(a_first_stalls, clk, rst_n, in_valid && in_ready && command == txrcp_pkg::CMD_BYTE && first_of_frame, !in_ready)

endmodule

bind tx_frame_ring_chunk_pump_top txrcp_checker u_txrcp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .first_of_frame (first_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_byte       (out_byte),
    .last_of_chunk  (last_of_chunk)
);

`default_nettype wire
